/* design/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constant for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

   // ASCII code of '0'
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // controller -> datapath commands
   typedef struct packed {
      logic load;     // take a new number, clear BCD and bit counter, preset digit counter
      logic dabble;   // one add-3 / shift step
      logic skip;     // drop a leading zero digit
      logic emit;     // move top digit into the output register
   } b2da_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic bits_done;  // current dabble step is the final one
      logic top_zero;   // top BCD digit is zero
      logic last_pos;   // top BCD digit is the least significant one left
      logic out_free;   // output register can take a word this cycle
   } b2da_status_type;

endpackage : b2da_pkg

`default_nettype wire

/* design/binary_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned binary word to decimal ASCII digits, MSD first.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports                                  word
//   req      in         req_valid/req_ready, req_number        one binary number
//   rsp      out        rsp_valid/rsp_ready, rsp_digit_char,   one ASCII digit,
//                       rsp_last_digit                         last flags the LSD
//
// Sequence: accept, then INPUT_WIDTH double dabble steps (one bit per cycle),
//   then strip leading zeros (up to DIGIT_COUNT-1) and leave the strip step,
//   then send the digits one at a time as the output register frees. The
//   bit-serial dabble loop takes the largest share of a conversion.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// Stalls: rsp is registered; a digit waits there while the next is readied.
//   req_ready is high only between numbers, once the last digit has been
//   handed to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_unit
   import b2da_pkg::*;
#(
   parameter int INPUT_WIDTH = 32,
   parameter int DIGIT_COUNT = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [INPUT_WIDTH-1:0] req_number,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [5:0]                  rsp_digit_char,
   output logic                        rsp_last_digit
);

   b2da_cmd_type    cmd;     // sequencer commands
   b2da_status_type status;  // datapath flags

   // sequencer
   b2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // BCD shift register, counters and output register
   b2da_dpath #(
      .INPUT_WIDTH (INPUT_WIDTH),
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule : binary_to_decimal_ascii_unit

`default_nettype wire

/* design/b2da_dpath.sv */
// ----------------------------------------------------------------------------
// b2da_dpath
// Double dabble shift register, digit counters and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_dpath
   import b2da_pkg::*;
#(
   parameter int INPUT_WIDTH = 32,
   parameter int DIGIT_COUNT = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire b2da_cmd_type           cmd,
   output b2da_status_type             status,
   input  wire logic [INPUT_WIDTH-1:0] req_number,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [5:0]                  rsp_digit_char,
   output logic                        rsp_last_digit
);

   localparam int BCD_W = 4 * DIGIT_COUNT;
   localparam int BCW   = (INPUT_WIDTH > 1) ? $clog2(INPUT_WIDTH) : 1;
   localparam int DCW   = $clog2(DIGIT_COUNT + 1);

   logic [INPUT_WIDTH-1:0] bin_ff,     bin_in;
   logic [BCD_W-1:0]       bcd_ff,     bcd_in;
   logic [BCW-1:0]         bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0]         dig_cnt_ff, dig_cnt_in;
   logic                   valid_ff,   valid_in;
   logic [5:0]             char_ff,    char_in;
   logic                   last_ff,    last_in;

   logic [BCD_W-1:0]       bcd_adj;
   logic [3:0]             top_digit;

   // add 3 to every digit of 5 or more; digits are independent
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   assign status.bits_done = (bit_cnt_ff == BCW'(INPUT_WIDTH - 1));
   assign status.top_zero  = (top_digit == 4'd0);
   assign status.last_pos  = (dig_cnt_ff == DCW'(1));
   assign status.out_free  = !valid_ff || rsp_ready;

   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (cmd.load) begin
         bin_in     = req_number;
         bcd_in     = '0;
         bit_cnt_in = '0;
         dig_cnt_in = DCW'(DIGIT_COUNT);
      end else if (cmd.dabble) begin
         // carry out of the top digit drops off the end
         bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[INPUT_WIDTH-1]};
         bin_in     = {bin_ff[INPUT_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + BCW'(1);
      end else if (cmd.skip || cmd.emit) begin
         bcd_in     = {bcd_ff[BCD_W-5:0], 4'd0};
         dig_cnt_in = dig_cnt_ff - DCW'(1);
      end
      if (cmd.emit) begin
         char_in  = ASCII_ZERO + {2'b00, top_digit};
         last_in  = status.last_pos;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule : b2da_dpath

`default_nettype wire

/* design/b2da_ctrl.sv */
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: accept, convert, strip leading zeros, emit digits.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_ctrl
   import b2da_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire b2da_status_type status,
   output b2da_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SKIP = 4'b0100,
      ST_EMIT = 4'b1000
   } b2da_state_type;

   b2da_state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.dabble = 1'b1;
            if (status.bits_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // a zero value keeps its last digit
            if (status.top_zero && !status.last_pos) begin
               cmd.skip = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_pos) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : b2da_ctrl

`default_nettype wire
